// ===== design/fccs_pkg.sv =====
package fccs_pkg;

    // Port widths fixed by the interface.
    localparam int SEC_PORT_W = 24;
    localparam int GRID_W     = 7;
    localparam int FC_W       = 17;
    localparam int EC_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 2 * SEC_PORT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SECONDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECONDS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [SEC_PORT_W-1:0] RST_FRAME_RATE  = 24'd1638400;
    localparam logic [SEC_PORT_W-1:0] RST_MIN_SECONDS = 24'd0;
    localparam logic [SEC_PORT_W-1:0] RST_MAX_SECONDS = 24'd1310720;
    localparam logic [GRID_W-1:0]     RST_GRID_STEP   = 7'd8;

    // Error codes.
    localparam logic [EC_W-1:0] ERR_OK       = 2'd0;
    localparam logic [EC_W-1:0] ERR_ZERO_RATE = 2'd1;
    localparam logic [EC_W-1:0] ERR_WINDOW   = 2'd2;
    localparam logic [EC_W-1:0] ERR_ZERO_CNT = 2'd3;

    localparam logic [FC_W-1:0] FRAMES_MAX = 17'h1FFFF;

    // One step of restoring division by the grid step: shift in the next
    // dividend bit and subtract the divisor when it fits.
    function automatic logic [GRID_W-1:0] rem_step(
        input logic [GRID_W-1:0] rem,
        input logic              dbit,
        input logic [GRID_W-1:0] div
    );
        logic [GRID_W:0] t;
        t = {rem, dbit};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[GRID_W-1:0];
    endfunction

endpackage

// ===== design/frame_count_clamp_snap.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_duration (24 b, unsigned seconds)
// result    out        o_valid / i_stall  o_frame_count (17 b), o_error_code (2 b)
// config    in         i_cfg_we           i_cfg_idx (2 b), i_cfg_data (24 b)
//
// One item per cycle is accepted unless a finished result is held back.
// An accepted item passes the input, product, rounding and clamp registers, then
// one bit-serial remainder stage per dividend bit (QW = 49 - 2*SECONDS_FRAC_BITS
// bits), and finally the snap and output registers.
// Synchronous active-low reset clears all valid bits and loads the defaults.
// A held result freezes the whole pipeline and raises o_stall; nothing is lost.
module frame_count_clamp_snap
    import fccs_pkg::*;
#(
    parameter int SECONDS_FRAC_BITS = 16,
    parameter int SECONDS_INT_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SEC_PORT_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SEC_PORT_W-1:0] i_duration,
    // Result channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FC_W-1:0]       o_frame_count,
    output logic [EC_W-1:0]       o_error_code
);

    // Fixed-point geometry. Both factors carry SECONDS_FRAC_BITS fraction
    // bits, so the exact product carries twice as many; they are dropped
    // with round-half-to-even.
    localparam int SEC_BITS  = SECONDS_INT_BITS + SECONDS_FRAC_BITS;
    localparam int SHIFT     = 2 * SECONDS_FRAC_BITS;
    localparam int QW        = PROD_W + 1 - SHIFT;
    localparam int CW        = (QW + 1 > FC_W) ? QW + 1 : FC_W;
    localparam logic [SEC_PORT_W-1:0] SEC_MASK = (SEC_BITS >= SEC_PORT_W) ?
        {SEC_PORT_W{1'b1}} : SEC_PORT_W'((64'd1 << SEC_BITS) - 64'd1);
    localparam logic [PROD_W-1:0] REM_MASK = PROD_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic [PROD_W-1:0] HALF     = PROD_W'(64'd1 << (SHIFT - 1));

    // Item state through the clamp and remainder stages.
    typedef struct packed {
        logic [QW-1:0]     raw_c;
        logic [QW-1:0]     lo_f;
        logic [QW-1:0]     hi_f;
        logic [QW-1:0]     a1;
        logic [QW-1:0]     a2;
        logic [GRID_W-1:0] r1;
        logic [GRID_W-1:0] r2;
        logic [EC_W-1:0]   err;
    } t_div;

    // ------------------------------------------------------------------
    // Configuration registers. The user must change them only while no item
    // is in flight; the block does not enforce it. The product, clamp, remainder and snap stages read them directly.
    // ------------------------------------------------------------------
    logic [SEC_PORT_W-1:0] r_frame_rate;
    logic [SEC_PORT_W-1:0] r_min_seconds;
    logic [SEC_PORT_W-1:0] r_max_seconds;
    logic [GRID_W-1:0]     r_grid_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate  <= RST_FRAME_RATE;
            r_min_seconds <= RST_MIN_SECONDS;
            r_max_seconds <= RST_MAX_SECONDS;
            r_grid_step   <= RST_GRID_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_RATE:  r_frame_rate  <= i_cfg_data;
                CFG_MIN_SECONDS: r_min_seconds <= i_cfg_data;
                CFG_MAX_SECONDS: r_max_seconds <= i_cfg_data;
                CFG_GRID_STEP:   r_grid_step   <= i_cfg_data[GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [SEC_PORT_W-1:0] rate_m;
    logic [SEC_PORT_W-1:0] lo_s;
    logic [SEC_PORT_W-1:0] hi_s;
    logic [GRID_W-1:0]     grid_g;
    logic                  win_inv;
    logic                  rate_zero;

    assign rate_m    = r_frame_rate & SEC_MASK;
    assign lo_s      = r_min_seconds & SEC_MASK;
    assign hi_s      = r_max_seconds & SEC_MASK;
    // A grid step of zero behaves as a step of one.
    assign grid_g    = (r_grid_step == '0) ? GRID_W'(1) : r_grid_step;
    assign win_inv   = hi_s < lo_s;
    assign rate_zero = rate_m == '0;

    // The whole pipeline advances unless a finished result is held back.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // Stage 0: input register.
    // ------------------------------------------------------------------
    logic                  r_s0_v;
    logic [SEC_PORT_W-1:0] r_s0_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_dur <= i_duration & SEC_MASK;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: exact products of the duration and both window bounds with
    // the frame rate.
    // ------------------------------------------------------------------
    logic              r_s1_v;
    logic [PROD_W-1:0] r_p_dur;
    logic [PROD_W-1:0] r_p_lo;
    logic [PROD_W-1:0] r_p_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dur <= PROD_W'(r_s0_dur) * PROD_W'(rate_m);
            r_p_lo  <= PROD_W'(lo_s) * PROD_W'(rate_m);
            r_p_hi  <= PROD_W'(hi_s) * PROD_W'(rate_m);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round half to even.
    // ------------------------------------------------------------------
    function automatic logic [QW-1:0] round_even(input logic [PROD_W-1:0] p);
        logic [QW-1:0]     q;
        logic [PROD_W-1:0] rem;
        q   = QW'(p >> SHIFT);
        rem = p & REM_MASK;
        if (rem > HALF || (rem == HALF && q[0])) begin
            q = q + QW'(1);
        end
        return q;
    endfunction

    logic          r_s2_v;
    logic [QW-1:0] r_raw_f;
    logic [QW-1:0] r_lo_f;
    logic [QW-1:0] r_hi_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_raw_f <= round_even(r_p_dur);
            r_lo_f  <= round_even(r_p_lo);
            r_hi_f  <= round_even(r_p_hi);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: clamp to the window and pick the error code. The two
    // dividends for the remainder stages are the clamped count minus one
    // (floor snap) and the lower bound minus one (ceiling snap).
    // ------------------------------------------------------------------
    logic [QW-1:0] clamp_lo;
    logic [QW-1:0] clamp_c;
    t_div          n_dv0;

    always_comb begin
        clamp_lo = (r_raw_f < r_lo_f) ? r_lo_f : r_raw_f;
        clamp_c  = (clamp_lo > r_hi_f) ? r_hi_f : clamp_lo;
        n_dv0.raw_c = clamp_c;
        n_dv0.lo_f  = r_lo_f;
        n_dv0.hi_f  = r_hi_f;
        n_dv0.a1    = clamp_c - QW'(1);
        n_dv0.a2    = r_lo_f - QW'(1);
        n_dv0.r1    = '0;
        n_dv0.r2    = '0;
        if (win_inv) begin
            n_dv0.err = ERR_WINDOW;
        end else if (rate_zero) begin
            n_dv0.err = ERR_ZERO_RATE;
        end else if (r_hi_f < r_lo_f) begin
            n_dv0.err = ERR_WINDOW;
        end else if (clamp_c == '0) begin
            n_dv0.err = ERR_ZERO_CNT;
        end else begin
            n_dv0.err = ERR_OK;
        end
    end

    // ------------------------------------------------------------------
    // Remainder stages: each consumes one bit of both dividends, MSB first.
    // After QW stages r1 and r2 hold the remainders modulo the grid step.
    // ------------------------------------------------------------------
    logic r_dv_v [0:QW];
    t_div r_dv   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        t_div n_dv;

        always_comb begin
            n_dv    = r_dv[k-1];
            n_dv.r1 = rem_step(r_dv[k-1].r1, r_dv[k-1].a1[QW-k], grid_g);
            n_dv.r2 = rem_step(r_dv[k-1].r2, r_dv[k-1].a2[QW-k], grid_g);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_dv;
            end
        end
    end

    // ------------------------------------------------------------------
    // Snap stage: floor snap is the count minus the remainder of the count minus one;
    // the ceiling snap of the lower bound adds the distance to the next grid point.
    // ------------------------------------------------------------------
    logic            r_e1_v;
    logic [CW-1:0]   r_fl;
    logic [CW-1:0]   r_up;
    logic [CW-1:0]   r_e1_lo;
    logic [CW-1:0]   r_e1_hi;
    logic [EC_W-1:0] r_e1_err;
    logic [GRID_W-1:0] up_adj;

    assign up_adj = (r_dv[QW].r2 == '0) ? '0 : grid_g - r_dv[QW].r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (en) begin
            r_e1_v <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl     <= CW'(r_dv[QW].raw_c) - CW'(r_dv[QW].r1);
            r_up     <= CW'(r_dv[QW].lo_f) + CW'(up_adj);
            r_e1_lo  <= CW'(r_dv[QW].lo_f);
            r_e1_hi  <= CW'(r_dv[QW].hi_f);
            r_e1_err <= r_dv[QW].err;
        end
    end

    // ------------------------------------------------------------------
    // Output register: choose the snapped count, cap and saturate it, and zero it on an error.
    // ------------------------------------------------------------------
    logic [CW-1:0]   sel_c;
    logic [FC_W-1:0] n_frames;

    always_comb begin
        sel_c = r_fl;
        if (r_fl < r_e1_lo) begin
            sel_c = (r_up < r_e1_hi) ? r_up : r_e1_hi;
        end
        if (sel_c > CW'(FRAMES_MAX)) begin
            sel_c = CW'(FRAMES_MAX);
        end
        if (r_e1_err != ERR_OK) begin
            sel_c = '0;
        end
        n_frames = sel_c[FC_W-1:0];
    end

    logic            r_out_v;
    logic [FC_W-1:0] r_out_frames;
    logic [EC_W-1:0] r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_frames <= n_frames;
            r_out_err    <= r_e1_err;
        end
    end

    assign o_valid       = r_out_v;
    assign o_frame_count = r_out_frames;
    assign o_error_code  = r_out_err;

endmodule

// ===== design/fccs_checker.sv =====
module fccs_checker
    import fccs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [FC_W-1:0]       o_frame_count,
    input logic [EC_W-1:0]       o_error_code
);

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_count)
                               && $stable(o_error_code))
        else $error("result changed while stalled");

    // The input side only stalls when a result is waiting and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // Any error forces a zero frame count.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_OK |-> o_frame_count == '0)
        else $error("nonzero frame count with an error");

    // A good result always has at least one frame.
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == ERR_OK |-> o_frame_count != '0)
        else $error("zero frame count without an error");

endmodule

bind frame_count_clamp_snap fccs_checker u_fccs_checker (.*);

// ===== sim/frame_count_clamp_snap_test.sv =====
module frame_count_clamp_snap_test;
    import fccs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Fraction bits of the seconds format at the default parameters. A product
    // of two such values carries twice as many fraction bits.
    localparam int FRAC_BITS = 16;
    // Closing-wait base in cycles; it is shorter than the block's register chain.
    localparam int PIPE_LAT  = 5 + 49 - 2 * FRAC_BITS;
    // Length of the long result hold-off in the backpressure test.
    localparam int LONG_HOLD = 150;
    localparam logic [2*FRAC_BITS-1:0] HALF_FRAME = {1'b1, {(2*FRAC_BITS-1){1'b0}}};

    typedef struct packed {
        logic [FC_W-1:0] frame_count;
        logic [EC_W-1:0] error_code;
    } t_frame_result;

    // Every input of the block starts at a known value.
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_FRAME_RATE;
    logic [SEC_PORT_W-1:0] cfg_data   = '0;
    logic                  dur_valid  = 1'b0;
    logic [SEC_PORT_W-1:0] duration   = '0;
    logic                  res_stall  = 1'b0;
    logic                  dur_stall;
    logic                  res_valid;
    logic [FC_W-1:0]       frame_count;
    logic [EC_W-1:0]       error_code;

    // Our own copy of the configuration registers, loaded with the reset values.
    logic [SEC_PORT_W-1:0] rate_q = RST_FRAME_RATE;
    logic [SEC_PORT_W-1:0] min_q  = RST_MIN_SECONDS;
    logic [SEC_PORT_W-1:0] max_q  = RST_MAX_SECONDS;
    logic [GRID_W-1:0]     grid_q = RST_GRID_STEP;

    // Results still owed by the block, oldest first.
    t_frame_result expected_frames[$];
    int            mismatch_count = 0;
    // When set, both sides insert random idle bursts.
    bit            idle_on        = 1'b1;
    // A nonzero value asks the result side for one long hold-off of that many cycles.
    int            hold_cycles    = 0;

    always #2 clk = ~clk;

    frame_count_clamp_snap uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_valid       (dur_valid),
        .o_stall       (dur_stall),
        .i_duration    (duration),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_frame_count (frame_count),
        .o_error_code  (error_code)
    );

    // Multiplies seconds by frames per second, both unsigned fixed point, and
    // rounds the exact product to a whole frame count, ties going to the even
    // neighbor.
    function automatic logic [FC_W-1:0] round_frames(
        input logic [SEC_PORT_W-1:0] secs,
        input logic [SEC_PORT_W-1:0] rate
    );
        logic [PROD_W-1:0]      prod;
        logic [FC_W-1:0]        whole;
        logic [2*FRAC_BITS-1:0] frac;
        prod  = {{SEC_PORT_W{1'b0}}, secs} * {{SEC_PORT_W{1'b0}}, rate};
        whole = FC_W'(prod[PROD_W-1:2*FRAC_BITS]);
        frac  = prod[2*FRAC_BITS-1:0];
        if (frac > HALF_FRAME || (frac == HALF_FRAME && whole[0])) begin
            whole = whole + FC_W'(1);
        end
        return whole;
    endfunction

    // Frame count and error code that one duration must produce under the
    // current register copy.
    function automatic t_frame_result predict_frames(input logic [SEC_PORT_W-1:0] secs);
        t_frame_result r;
        int step;
        int lo_f;
        int hi_f;
        int raw;
        int frames;
        r.frame_count = '0;
        r.error_code  = ERR_OK;
        // A zero grid step behaves as a step of one.
        step = (grid_q == '0) ? 1 : int'(grid_q);
        // An inverted window wins over a zero rate.
        if (max_q < min_q) begin
            r.error_code = ERR_WINDOW;
        end else if (rate_q == '0) begin
            r.error_code = ERR_ZERO_RATE;
        end else begin
            lo_f = int'(round_frames(min_q, rate_q));
            hi_f = int'(round_frames(max_q, rate_q));
            raw  = int'(round_frames(secs, rate_q));
            if (hi_f < lo_f) begin
                r.error_code = ERR_WINDOW;
            end else begin
                if (raw < lo_f) raw = lo_f;
                if (raw > hi_f) raw = hi_f;
                if (raw == 0) begin
                    r.error_code = ERR_ZERO_CNT;
                end else begin
                    // Floor onto the grid k*step+1. If that drops below the
                    // window, round the lower bound up onto the grid instead
                    // and cap it at the upper bound.
                    frames = ((raw - 1) / step) * step + 1;
                    if (frames < lo_f) begin
                        frames = ((lo_f - 1 + step - 1) / step) * step + 1;
                        if (frames > hi_f) frames = hi_f;
                    end
                    if (frames > int'(FRAMES_MAX)) frames = int'(FRAMES_MAX);
                    r.frame_count = frames[FC_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // Offers one duration and holds it until the block takes it. Called at a
    // rising edge and returns at the edge where the item was accepted, or
    // later if a random sender gap follows. The stall is sampled on the
    // falling edge, where everything driven at the rising edge has settled.
    task automatic send_duration(input logic [SEC_PORT_W-1:0] secs);
        bit taken;
        taken = 1'b0;
        dur_valid <= 1'b1;
        duration  <= secs;
        while (!taken) begin
            @(negedge clk);
            taken = !dur_stall;
            @(posedge clk);
        end
        expected_frames.insert(expected_frames.size(), predict_frames(secs));
        if (idle_on && $urandom_range(0, 5) == 0) begin
            dur_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every owed result has come out,
    // then waits on so that the last one has really left the block.
    task automatic wait_drained();
        dur_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers, one per cycle, once the block is empty. The
    // grid step is passed at full port width so that junk above its seven
    // bits can be sent too; the block must ignore it.
    task automatic load_config(
        input logic [SEC_PORT_W-1:0] rate,
        input logic [SEC_PORT_W-1:0] min_secs,
        input logic [SEC_PORT_W-1:0] max_secs,
        input logic [SEC_PORT_W-1:0] grid
    );
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_RATE;
        cfg_data <= rate;
        @(posedge clk);
        cfg_idx  <= CFG_MIN_SECONDS;
        cfg_data <= min_secs;
        @(posedge clk);
        cfg_idx  <= CFG_MAX_SECONDS;
        cfg_data <= max_secs;
        @(posedge clk);
        cfg_idx  <= CFG_GRID_STEP;
        cfg_data <= grid;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rate_q = rate;
        min_q  = min_secs;
        max_q  = max_secs;
        grid_q = grid[GRID_W-1:0];
    endtask

    // Reset values: 25 fps, window 0 to 20 s, step 8. Zero seconds gives no
    // frame at all, the largest duration clamps to 500 frames, and half-second
    // durations land on exact ties (12.5 and 37.5 frames).
    task automatic test_reset_defaults();
        send_duration('0);
        send_duration('1);
        send_duration(24'h008000);
        send_duration(24'h018000);
    endtask

    // At 1 fps a fraction of exactly one half is a tie. Both sides of a tie,
    // ties to even from odd and even neighbors, and the top of the range.
    task automatic test_rounding();
        load_config(24'h010000, '0, '1, 24'd1);
        send_duration(24'h008000);
        send_duration(24'h008001);
        send_duration(24'h007FFF);
        send_duration(24'h018000);
        send_duration(24'h028000);
        send_duration('1);
    endtask

    // Each error code. With both a zero rate and an inverted window, the
    // window error must be reported.
    task automatic test_error_codes();
        load_config('0, 24'h020000, 24'h010000, 24'd8);
        send_duration(24'h050000);
        load_config('0, '0, 24'h010000, 24'd8);
        send_duration(24'h050000);
        load_config(24'h010000, '0, '0, 24'd8);
        send_duration(24'h050000);
    endtask

    // Grid snapping: the snap-up path with and without the cap at the upper
    // bound, a zero step with junk above it, the largest nominal step, and a
    // step above that range.
    task automatic test_grid_snap();
        load_config(24'h010000, 24'h0A0000, 24'h0F0000, 24'd8);
        send_duration('0);
        load_config(24'h010000, 24'h0A0000, 24'h640000, 24'd8);
        send_duration(24'h0C0000);
        load_config(24'h010000, '0, '1, 24'hFFFF00);
        send_duration(24'h250000);
        load_config(24'h010000, '0, '1, 24'd64);
        send_duration(24'hC80000);
        load_config(24'h010000, '0, '1, 24'hABCD7F);
        send_duration(24'hC80000);
    endtask

    // Largest rate and durations: the product reaches 65536 frames, well
    // inside the 17-bit result count. A window pinned at the top with a
    // coarse step exercises the snap-up against the cap there.
    task automatic test_extremes();
        load_config('1, '0, '1, 24'd1);
        send_duration('1);
        send_duration(24'h000001);
        load_config('1, '1, '1, 24'd64);
        send_duration('0);
    endtask

    // Random phases, each with its own register setting. Most settings are
    // sane windows at ordinary frame rates so that clamping, snapping and
    // rounding all get exercised; a few are inverted, degenerate or extreme.
    task automatic test_random_windows();
        logic [SEC_PORT_W-1:0] rate;
        logic [SEC_PORT_W-1:0] lo;
        logic [SEC_PORT_W-1:0] hi;
        logic [SEC_PORT_W-1:0] grid;
        logic [SEC_PORT_W-1:0] secs;
        int phase;
        int n;
        for (phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 9))
                0:       rate = '1;
                1:       rate = 24'd1;
                2:       rate = SEC_PORT_W'($urandom());
                // Odd whole frame rates turn odd half-seconds into exact ties.
                3, 4, 5: rate = SEC_PORT_W'(($urandom_range(1, 60) | 1) << FRAC_BITS);
                default: rate = SEC_PORT_W'($urandom_range(1 << FRAC_BITS,
                                                           60 << FRAC_BITS));
            endcase
            if ($urandom_range(0, 19) == 0) rate = '0;
            case ($urandom_range(0, 9))
                0: begin
                    lo = '0;
                    hi = '1;
                end
                1: begin
                    lo = SEC_PORT_W'($urandom());
                    hi = SEC_PORT_W'($urandom());
                end
                2: begin
                    lo = SEC_PORT_W'($urandom_range(0, 4 << FRAC_BITS));
                    hi = lo;
                end
                default: begin
                    lo = SEC_PORT_W'($urandom_range(0, 30 << FRAC_BITS));
                    hi = lo + SEC_PORT_W'($urandom_range(0, 30 << FRAC_BITS));
                end
            endcase
            case ($urandom_range(0, 7))
                0:       grid = SEC_PORT_W'($urandom_range(0, 24'h1FFFF) << GRID_W);
                1:       grid = SEC_PORT_W'($urandom());
                default: grid = SEC_PORT_W'($urandom_range(1, 64));
            endcase
            load_config(rate, lo, hi, grid);
            // Every third phase runs without any idling.
            idle_on = (phase % 3 != 2);
            for (n = 0; n < 55; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: secs = SEC_PORT_W'($urandom());
                    2:    secs = SEC_PORT_W'($urandom_range(0, 24'h3FFFF));
                    3:    secs = SEC_PORT_W'(($urandom_range(0, 255) * 2 + 1)
                                             << (FRAC_BITS - 1));
                    default: begin
                        if (hi >= lo) secs = SEC_PORT_W'($urandom_range(lo, hi));
                        else secs = SEC_PORT_W'($urandom());
                    end
                endcase
                send_duration(secs);
            end
        end
        idle_on = 1'b1;
    endtask

    // The result side holds off long enough for the pipeline to fill and
    // push back on the input while items keep coming. Afterwards the sender
    // waits for an empty block between short bursts.
    task automatic test_backpressure();
        int n;
        int burst;
        load_config(SEC_PORT_W'(25 << FRAC_BITS), '0, '1, 24'd4);
        hold_cycles = LONG_HOLD;
        for (n = 0; n < 60; n++) send_duration(SEC_PORT_W'($urandom()));
        wait_drained();
        for (burst = 0; burst < 3; burst++) begin
            for (n = 0; n < 8; n++) send_duration(SEC_PORT_W'($urandom()));
            wait_drained();
        end
    endtask

    // Closing stretch at full rate: no gaps on either side.
    task automatic test_streaming();
        int n;
        load_config(SEC_PORT_W'(24 << FRAC_BITS), 24'h010000, 24'h400000, 24'd8);
        idle_on = 1'b0;
        for (n = 0; n < 60; n++) send_duration(SEC_PORT_W'($urandom()));
    endtask

    // Result-side stall: random short bursts while idling is enabled, and
    // one long hold-off when a test asks for it. Every burst ends with the
    // stall released before the next one can start.
    initial begin : result_stall_gen
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                res_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                res_stall <= 1'b0;
            end else if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Each result taken at the coming rising edge is checked against the
    // oldest owed one. Sampling on the falling edge keeps this clear of the
    // updates at the rising edge.
    always @(negedge clk) begin : result_check
        t_frame_result want;
        if (rst_n && res_valid === 1'b1 && !res_stall) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: result with no item pending: expected none, got %0d / %0d",
                         $time, frame_count, error_code);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                if (frame_count !== want.frame_count) begin
                    $display("%0t: frame_count expected %0d, got %0d",
                             $time, want.frame_count, frame_count);
                    mismatch_count++;
                end
                if (error_code !== want.error_code) begin
                    $display("%0t: error_code expected %0d, got %0d",
                             $time, want.error_code, error_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : run_tests
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_rounding();
        test_error_codes();
        test_grid_snap();
        test_extremes();
        test_random_windows();
        test_backpressure();
        test_streaming();
        wait_drained();
        // Anything still coming out now would be a result with no item.
        repeat (2 * PIPE_LAT) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("PASS frame_count_clamp_snap");
        end else begin
            $display("FAIL frame_count_clamp_snap");
        end
        $finish;
    end

    // Fails a run that never reaches its end.
    initial begin : watchdog
        #2_000_000;
        $display("FAIL frame_count_clamp_snap");
        $finish;
    end

endmodule
